// ===== src/dllrc_pkg.sv =====
// ---------------------------------------------------------------------------
// dllrc_pkg
// Shared types and constants of the door lock relock controller.
// ---------------------------------------------------------------------------
`default_nettype none

package dllrc_pkg;

   localparam int TimeoutWidth = 24;
   localparam int DelayWidth   = 16;

   localparam logic [TimeoutWidth-1:0] TimeoutReset = 24'd60000;
   localparam logic [DelayWidth-1:0]   DelayReset   = 16'd1500;
   localparam logic [TimeoutWidth-1:0] CounterMax   = 24'hFFFFFF;

   // Register indexes of the configuration port
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_DELAY   = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_UNLOCK       = 2'd1,
      OP_LOCK         = 2'd2,
      OP_LOCAL_UNLOCK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      EV_LOCKED      = 3'd0,
      EV_UNLOCKED    = 3'd1,
      EV_ALREADY     = 3'd2,
      EV_TIMEOUT     = 3'd3,
      EV_DOOR_OPEN   = 3'd4,
      EV_DOOR_SHUT   = 3'd5
   } event_type;

   typedef struct packed {
      logic      relay_released;
      event_type event_code;
      logic      last_event;
   } rsp_item_type;

   // Events produced by one transaction, first event in r0
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type r0;
      rsp_item_type r1;
   } step_out_type;

endpackage

`default_nettype wire

// ===== src/dllrc_step.sv =====
// ---------------------------------------------------------------------------
// dllrc_step
// Lock phase machine: computes the events of one transaction and updates
// the phase, door history and phase counter when the transaction retires.
// ---------------------------------------------------------------------------
`default_nettype none

module dllrc_step (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 fire,
   input  wire  dllrc_pkg::op_type             operation,
   input  wire                                 door_shut,
   input  wire  [dllrc_pkg::TimeoutWidth-1:0]  open_limit,
   input  wire  [dllrc_pkg::DelayWidth-1:0]    relock_delay,
   output dllrc_pkg::step_out_type             step_out
);
   import dllrc_pkg::*;

   typedef enum logic [1:0] {
      PH_LOCKED      = 2'd0,
      PH_WAIT_OPEN   = 2'd1,
      PH_OPENED      = 2'd2,
      PH_RELOCK_WAIT = 2'd3
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic                     door_was_closed_ff, door_was_closed_in;
   logic [TimeoutWidth-1:0]  counter_ff, counter_in;
   logic [TimeoutWidth-1:0]  counter_sat;
   logic                     edge_seen;
   logic                     cur_released;

   assign counter_sat  = (counter_ff == CounterMax) ? counter_ff
                                                    : counter_ff + 1'b1;
   assign edge_seen    = (door_shut != door_was_closed_ff);
   assign cur_released = (phase_ff != PH_LOCKED);

   always_comb begin
      phase_in           = phase_ff;
      door_was_closed_in = door_was_closed_ff;
      counter_in         = counter_ff;
      step_out           = '0;
      step_out.r0.event_code = EV_LOCKED;
      step_out.r1.event_code = EV_LOCKED;

      case (operation)
         OP_UNLOCK: begin
            step_out.count = 2'd1;
            step_out.r0.relay_released = 1'b1;
            if (phase_ff == PH_LOCKED) begin
               phase_in   = PH_WAIT_OPEN;
               counter_in = '0;
               step_out.r0.event_code = EV_UNLOCKED;
            end else begin
               step_out.r0.event_code = EV_ALREADY;
            end
         end
         OP_LOCK: begin
            phase_in       = PH_LOCKED;
            counter_in     = '0;
            step_out.count = 2'd1;
         end
         OP_LOCAL_UNLOCK: begin
            if (phase_ff == PH_LOCKED) begin
               phase_in       = PH_WAIT_OPEN;
               counter_in     = '0;
               step_out.count = 2'd1;
               step_out.r0.event_code     = EV_UNLOCKED;
               step_out.r0.relay_released = 1'b1;
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_RELOCK_WAIT) begin
               // Edge reporting pauses until the re-check
               if (counter_ff >= {{(TimeoutWidth-DelayWidth){1'b0}}, relock_delay}) begin
                  counter_in = '0;
                  if (door_shut) begin
                     phase_in       = PH_LOCKED;
                     step_out.count = 2'd1;
                  end else begin
                     phase_in = PH_OPENED;
                  end
               end else begin
                  counter_in = counter_sat;
               end
            end else begin
               if (edge_seen) begin
                  door_was_closed_in = door_shut;
                  step_out.count     = 2'd1;
                  step_out.r0.event_code =
                     door_shut ? EV_DOOR_SHUT : EV_DOOR_OPEN;
                  step_out.r0.relay_released = cur_released;
               end
               if (phase_ff == PH_WAIT_OPEN) begin
                  if (!door_shut) begin
                     phase_in   = PH_OPENED;
                     counter_in = '0;
                  end else if (counter_sat >= open_limit) begin
                     // Timeout relocks, reported after the door edge event when an edge is seen too
                     phase_in   = PH_LOCKED;
                     counter_in = '0;
                     if (edge_seen) begin
                        step_out.count = 2'd2;
                        step_out.r1.event_code = EV_TIMEOUT;
                     end else begin
                        step_out.count = 2'd1;
                        step_out.r0.event_code = EV_TIMEOUT;
                     end
                  end else begin
                     counter_in = counter_sat;
                  end
               end else if (phase_ff == PH_OPENED) begin
                  if (door_shut) begin
                     phase_in   = PH_RELOCK_WAIT;
                     counter_in = '0;
                  end
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      step_out.r0.last_event = (step_out.count == 2'd1);
      step_out.r1.last_event = (step_out.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_LOCKED;
         door_was_closed_ff <= 1'b1;
         counter_ff         <= '0;
      end else if (fire) begin
         phase_ff           <= phase_in;
         door_was_closed_ff <= door_was_closed_in;
         counter_ff         <= counter_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/dllrc_out_fifo.sv =====
// ---------------------------------------------------------------------------
// dllrc_out_fifo
// Result queue: takes up to two events per cycle, hands out one per cycle while pop is high.
// ---------------------------------------------------------------------------
`default_nettype none

module dllrc_out_fifo #(
   parameter int DEPTH = 4
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire dllrc_pkg::step_out_type   push,
   input  wire                            pop,
   output dllrc_pkg::rsp_item_type        head,
   output logic                           head_valid,
   output logic                           room_for_two
);
   import dllrc_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] TwoLess  = CountWidth'(DEPTH - 2);

   rsp_item_type            entry_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
      ptr_inc = (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   assign wr_next      = ptr_inc(wr_ptr_ff);
   assign head         = entry_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != '0);
   assign room_for_two = (count_ff <= TwoLess);

   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CountWidth'(push.count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room_for_two)
      else $error("events pushed without room for two");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |=> head_valid)
      else $error("pushed event not visible at queue head");

   a_locked_relay: assert property (@(posedge clock) disable iff (reset)
      (head_valid && (head.event_code == EV_LOCKED || head.event_code == EV_TIMEOUT))
      |-> !head.relay_released)
      else $error("relay released on a lock event");

endmodule

`default_nettype wire

// ===== src/door_lock_relock_controller_core.sv =====
// ---------------------------------------------------------------------------
// door_lock_relock_controller_core
// Lock relay controller with door sensing, unlock timeout and relock delay.
// ---------------------------------------------------------------------------
// Each transaction waits in the input register, where the phase
// machine computes its events, which land in a result queue of OUT_DEPTH
// entries. A new transaction is taken every cycle as long as the queue has
// room for two events; the result port hands out one event per cycle while
// rsp_tready is high, so a transaction that causes two events (door edge
// plus unlock timeout) gives two results. Events reach rsp_ through the
// input register and the queue. Configuration writes are taken at any time,
// csr_ready is always high, and take effect on the next processed transaction.
`default_nettype none

module door_lock_relock_controller_core #(
   parameter int OUT_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   // input channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [0] door_shut, [7:1] zero
   input  wire  [1:0]  req_tuser,   // [1:0] operation
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_code, [3] relay_released, [7:4] zero
   output logic        rsp_tlast,   // last_event
   // configuration port
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [23:0] csr_wdata
);
   import dllrc_pkg::*;

   logic                     in_valid_ff;
   op_type                   op_ff;
   logic                     door_ff;
   logic [TimeoutWidth-1:0]  timeout_ff;
   logic [DelayWidth-1:0]    delay_ff;
   logic                     fire;
   logic                     room_for_two;
   logic                     head_valid;
   logic                     rsp_pop;
   step_out_type             step_out;
   step_out_type             push;
   rsp_item_type             head;

   assign fire       = in_valid_ff && room_for_two;
   assign req_tready = !in_valid_ff || room_for_two;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= op_type'(req_tuser);
         door_ff <= req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TimeoutReset;
         delay_ff   <= DelayReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_DELAY:   delay_ff   <= csr_wdata[DelayWidth-1:0];
            default:     delay_ff   <= delay_ff;
         endcase
      end
   end

   dllrc_step u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .operation      (op_ff),
      .door_shut      (door_ff),
      .open_limit     (timeout_ff),
      .relock_delay   (delay_ff),
      .step_out       (step_out)
   );

   // Drop the events when the transaction does not retire this cycle
   always_comb begin
      push = step_out;
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   assign rsp_pop = head_valid && rsp_tready;

   dllrc_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (rsp_pop),
      .head         (head),
      .head_valid   (head_valid),
      .room_for_two (room_for_two)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {4'b0000, head.relay_released, head.event_code};
   assign rsp_tlast  = head.last_event;

endmodule

`default_nettype wire
